/* rtl/one_wire_bus_master_macros.svh */
// Assertion macros for the 1-Wire bus master.
`ifndef ONE_WIRE_BUS_MASTER_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_MACROS_SVH

`ifndef SYNTH

`define OWBM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("owbm assertion failed");

`define OWBM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("owbm assertion failed");

`else

`define OWBM_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define OWBM_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/owbm_pkg.sv */
// Types, constants and helpers shared by the 1-Wire bus master.
`timescale 1ns / 1ps

package owbm_pkg;

  localparam int unsigned TIME_W    = 10;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [TIME_W-1:0] TIMER_MAX = 10'd1023;

  localparam logic [TIME_W-1:0] RST_RESET_LOW    = 10'd480;
  localparam logic [TIME_W-1:0] RST_PRES_WAIT    = 10'd70;
  localparam logic [TIME_W-1:0] RST_RECOVERY     = 10'd410;
  localparam logic [TIME_W-1:0] RST_WR_ONE_LOW   = 10'd6;
  localparam logic [TIME_W-1:0] RST_WR_ZERO_LOW  = 10'd60;
  localparam logic [TIME_W-1:0] RST_RD_LOW       = 10'd6;
  localparam logic [TIME_W-1:0] RST_RD_SAMPLE    = 10'd15;
  localparam logic [TIME_W-1:0] RST_SLOT         = 10'd70;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_LOW    = 3'd0,
    CFG_PRES_WAIT    = 3'd1,
    CFG_RECOVERY     = 3'd2,
    CFG_WR_ONE_LOW   = 3'd3,
    CFG_WR_ZERO_LOW  = 3'd4,
    CFG_RD_LOW       = 3'd5,
    CFG_RD_SAMPLE    = 3'd6,
    CFG_SLOT         = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RST_LOW   = 3'd1,
    PH_RST_WAIT  = 3'd2,
    PH_RST_RECOV = 3'd3,
    PH_SLOT      = 3'd4
  } phase_e;

  typedef struct packed {
    logic [TIME_W-1:0] reset_low_time;
    logic [TIME_W-1:0] presence_wait_time;
    logic [TIME_W-1:0] reset_recovery_time;
    logic [TIME_W-1:0] write_one_low_time;
    logic [TIME_W-1:0] write_zero_low_time;
    logic [TIME_W-1:0] read_low_time;
    logic [TIME_W-1:0] read_sample_time;
    logic [TIME_W-1:0] slot_time;
  } cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] tx_byte;
    logic       line_in;
  } cmd_t;

  typedef struct packed {
    logic       line_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
  } res_t;

  // A zero time behaves as one microsecond.
  function automatic logic [TIME_W-1:0] at_least_one(input logic [TIME_W-1:0] v);
    logic [TIME_W-1:0] r;
    r = (v == '0) ? {{(TIME_W-1){1'b0}}, 1'b1} : v;
    return r;
  endfunction

endpackage

/* rtl/owbm_ifs.sv */
// Handshake channel interfaces: command in, result out, register write.
`timescale 1ns / 1ps

interface owbm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] tx_byte;
  logic       line_in;

  modport source (output valid, output operation, output tx_byte, output line_in,
                  input ready);
  modport sink   (input valid, input operation, input tx_byte, input line_in,
                  output ready);
endinterface

interface owbm_res_if;
  logic       valid;
  logic       ready;
  logic       line_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] rx_byte;

  modport source (output valid, output line_low, output busy_res, output done_res,
                  output presence, output rx_byte, input ready);
  modport sink   (input valid, input line_low, input busy_res, input done_res,
                  input presence, input rx_byte, output ready);
endinterface

interface owbm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/one_wire_bus_master.sv */
// Top level of the standard-speed 1-Wire bus master.
`timescale 1ns / 1ps

// One command or microsecond-tick word is taken per clock and its result word
// is offered from an output register: the word is captured in an input
// register, one pass of the sequencer logic updates the bus state, and the
// result lands in an output register. Both stages move together, so a stalled
// result holds the input stage while its slot stays full. Timing registers are
// written over the configuration channel, which is always ready, and must only
// be changed while the block is idle.
module one_wire_bus_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  owbm_in_if.sink     in_i,
  owbm_res_if.source  res_o,
  owbm_cfg_if.sink    cfg_i
);

  owbm_pkg::cfg_t cfg_regs;
  owbm_pkg::cmd_t cmd_q;
  owbm_pkg::res_t res_d, res_q;
  logic           in_vld_q;
  logic           res_vld_q;
  logic           advance;
  logic           step;

  assign advance    = !res_vld_q || res_o.ready;
  assign step       = in_vld_q && advance;
  assign in_i.ready = !in_vld_q || advance;

  owbm_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg_regs)
  );

  owbm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cmd_i  (cmd_q),
    .cfg_i  (cfg_regs),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        res_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      cmd_q.operation <= in_i.operation;
      cmd_q.tx_byte   <= in_i.tx_byte;
      cmd_q.line_in   <= in_i.line_in;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid    = res_vld_q;
  assign res_o.line_low = res_q.line_low;
  assign res_o.busy_res = res_q.busy_res;
  assign res_o.done_res = res_q.done_res;
  assign res_o.presence = res_q.presence;
  assign res_o.rx_byte  = res_q.rx_byte;

endmodule

/* rtl/owbm_cfg_regs.sv */
// Timing register file, written through the configuration channel.
`timescale 1ns / 1ps

module owbm_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  owbm_cfg_if.sink          cfg_i,
  output owbm_pkg::cfg_t    cfg_o
);

  owbm_pkg::cfg_t regs_q, regs_d;
  logic           wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;
  assign cfg_o       = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (wr_en) begin
      case (owbm_pkg::cfg_idx_e'(cfg_i.index))
        owbm_pkg::CFG_RESET_LOW:   regs_d.reset_low_time      = cfg_i.data;
        owbm_pkg::CFG_PRES_WAIT:   regs_d.presence_wait_time  = cfg_i.data;
        owbm_pkg::CFG_RECOVERY:    regs_d.reset_recovery_time = cfg_i.data;
        owbm_pkg::CFG_WR_ONE_LOW:  regs_d.write_one_low_time  = cfg_i.data;
        owbm_pkg::CFG_WR_ZERO_LOW: regs_d.write_zero_low_time = cfg_i.data;
        owbm_pkg::CFG_RD_LOW:      regs_d.read_low_time       = cfg_i.data;
        owbm_pkg::CFG_RD_SAMPLE:   regs_d.read_sample_time    = cfg_i.data;
        owbm_pkg::CFG_SLOT:        regs_d.slot_time           = cfg_i.data;
        default:                   regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.reset_low_time      <= owbm_pkg::RST_RESET_LOW;
      regs_q.presence_wait_time  <= owbm_pkg::RST_PRES_WAIT;
      regs_q.reset_recovery_time <= owbm_pkg::RST_RECOVERY;
      regs_q.write_one_low_time  <= owbm_pkg::RST_WR_ONE_LOW;
      regs_q.write_zero_low_time <= owbm_pkg::RST_WR_ZERO_LOW;
      regs_q.read_low_time       <= owbm_pkg::RST_RD_LOW;
      regs_q.read_sample_time    <= owbm_pkg::RST_RD_SAMPLE;
      regs_q.slot_time           <= owbm_pkg::RST_SLOT;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

/* rtl/owbm_core.sv */
// Bus sequencer: phase, microsecond timer, bit slots and byte shifter.
`timescale 1ns / 1ps

`include "one_wire_bus_master_macros.svh"

module owbm_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  owbm_pkg::cmd_t    cmd_i,
  input  owbm_pkg::cfg_t    cfg_i,
  output owbm_pkg::res_t    res_o
);

  owbm_pkg::phase_e                  phase_q, phase_d;
  logic [owbm_pkg::TIME_W-1:0]       timer_q, timer_d;
  logic [2:0]                        bit_q, bit_d;
  logic [7:0]                        shift_q, shift_d;
  logic                              is_read_q, is_read_d;
  logic                              pres_q, pres_d;
  logic                              drive_q, drive_d;
  logic [7:0]                        rx_q, rx_d;
  logic                              done_d;

  logic [owbm_pkg::TIME_W-1:0]       t_inc, slot_len, sample_pt, sample_raw, low_len;
  owbm_pkg::op_e                     op;

  assign op = owbm_pkg::op_e'(cmd_i.operation);

  always_comb begin
    slot_len   = owbm_pkg::at_least_one(cfg_i.slot_time);
    sample_raw = owbm_pkg::at_least_one(cfg_i.read_sample_time);
    sample_pt  = (sample_raw > slot_len) ? slot_len : sample_raw;
    if (is_read_q) begin
      low_len = owbm_pkg::at_least_one(cfg_i.read_low_time);
    end else if (shift_q[bit_q]) begin
      low_len = owbm_pkg::at_least_one(cfg_i.write_one_low_time);
    end else begin
      low_len = owbm_pkg::at_least_one(cfg_i.write_zero_low_time);
    end
    t_inc = (timer_q == owbm_pkg::TIMER_MAX) ? timer_q
                                             : timer_q + owbm_pkg::TIME_W'(1);
  end

  always_comb begin
    phase_d   = phase_q;
    timer_d   = timer_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    is_read_d = is_read_q;
    pres_d    = pres_q;
    drive_d   = drive_q;
    rx_d      = rx_q;
    done_d    = 1'b0;

    if (op == owbm_pkg::OP_TICK) begin
      if (phase_q != owbm_pkg::PH_IDLE) begin
        timer_d = t_inc;
      end
      case (phase_q)
        owbm_pkg::PH_IDLE: begin
          timer_d = timer_q;
        end
        owbm_pkg::PH_RST_LOW: begin
          if (t_inc >= owbm_pkg::at_least_one(cfg_i.reset_low_time)) begin
            drive_d = 1'b0;
            timer_d = '0;
            phase_d = owbm_pkg::PH_RST_WAIT;
          end
        end
        owbm_pkg::PH_RST_WAIT: begin
          if (t_inc >= owbm_pkg::at_least_one(cfg_i.presence_wait_time)) begin
            pres_d  = ~cmd_i.line_in;
            timer_d = '0;
            if (cfg_i.reset_recovery_time == '0) begin
              phase_d = owbm_pkg::PH_IDLE;
              done_d  = 1'b1;
            end else begin
              phase_d = owbm_pkg::PH_RST_RECOV;
            end
          end
        end
        owbm_pkg::PH_RST_RECOV: begin
          if (t_inc >= cfg_i.reset_recovery_time) begin
            timer_d = '0;
            phase_d = owbm_pkg::PH_IDLE;
            done_d  = 1'b1;
          end
        end
        owbm_pkg::PH_SLOT: begin
          if (t_inc >= low_len) begin
            drive_d = 1'b0;
          end
          if (is_read_q && (t_inc == sample_pt)) begin
            shift_d = {cmd_i.line_in, shift_q[7:1]};
          end
          if (t_inc >= slot_len) begin
            timer_d = '0;
            if (bit_q == 3'd7) begin
              if (is_read_q) begin
                rx_d = shift_d;
              end
              bit_d   = '0;
              drive_d = 1'b0;
              phase_d = owbm_pkg::PH_IDLE;
              done_d  = 1'b1;
            end else begin
              bit_d   = bit_q + 3'd1;
              drive_d = 1'b1;
            end
          end
        end
        default: begin
          phase_d = owbm_pkg::PH_IDLE;
          timer_d = '0;
          drive_d = 1'b0;
        end
      endcase
    end else if (phase_q == owbm_pkg::PH_IDLE) begin
      timer_d = '0;
      bit_d   = '0;
      drive_d = 1'b1;
      if (op == owbm_pkg::OP_RESET) begin
        phase_d = owbm_pkg::PH_RST_LOW;
      end else begin
        phase_d   = owbm_pkg::PH_SLOT;
        is_read_d = (op == owbm_pkg::OP_READ);
        shift_d   = (op == owbm_pkg::OP_READ) ? 8'h00 : cmd_i.tx_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= owbm_pkg::PH_IDLE;
      timer_q   <= '0;
      bit_q     <= '0;
      shift_q   <= '0;
      is_read_q <= 1'b0;
      pres_q    <= 1'b0;
      drive_q   <= 1'b0;
      rx_q      <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      is_read_q <= is_read_d;
      pres_q    <= pres_d;
      drive_q   <= drive_d;
      rx_q      <= rx_d;
    end
  end

  // result word reflects state after this step
  always_comb begin
    res_o.line_low = drive_d;
    res_o.busy_res = (phase_d != owbm_pkg::PH_IDLE);
    res_o.done_res = done_d;
    res_o.presence = pres_d;
    res_o.rx_byte  = rx_d;
  end

  `OWBM_ASSERT_IMP(a_idle_released, clk_i, rst_ni, phase_q == owbm_pkg::PH_IDLE, !drive_q)
  `OWBM_ASSERT_IMP(a_bit_only_in_slot, clk_i, rst_ni, phase_q != owbm_pkg::PH_SLOT, bit_q == 3'd0)
  `OWBM_ASSERT_NXT(a_done_to_idle, clk_i, rst_ni, step_i && done_d, phase_q == owbm_pkg::PH_IDLE)

endmodule
